FILE: rtl/mahp_pkg.sv
// Package for the MPEG audio frame header parser.
// Holds the status codes, the header field struct and the bitrate / sample rate tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mahp_pkg;

    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 40;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VER   = 2'd1;
    localparam logic [1:0] ST_BAD_LAYER = 2'd2;
    localparam logic [1:0] ST_NO_SYNC   = 2'd3;

    localparam logic [1:0] VER_MPEG25    = 2'd0;
    localparam logic [1:0] VER_RESERVED  = 2'd1;
    localparam logic [1:0] VER_MPEG2     = 2'd2;
    localparam logic [1:0] VER_MPEG1     = 2'd3;

    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_2        = 2'd2;
    localparam logic [1:0] LAYER_1        = 2'd3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hE0;

    localparam logic [3:0] BIDX_FREE = 4'd0;
    localparam logic [3:0] BIDX_BAD  = 4'd15;
    localparam logic [1:0] SIDX_RSVD = 2'd3;

    // decoded header, version in the lowest bits
    typedef struct packed {
        logic [1:0]  chan_mode;
        logic        padding_flag;
        logic        sample_rate_known;
        logic [15:0] sample_rate_hz;
        logic        bitrate_known;
        logic [8:0]  bitrate_kbps;
        logic        crc_flag;
        logic [1:0]  layer_code;
        logic [1:0]  version_code;
    } hdr_fields_t;

    // rows: V1 L1, V1 L2, V1 L3, V2/2.5 L1, V2/2.5 L2/L3
    localparam logic [8:0] RATE_KBPS [0:4][0:15] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // rows: MPEG-1, MPEG-2, MPEG-2.5
    localparam logic [15:0] FREQ_HZ [0:2][0:3] = '{
        '{16'd44100, 16'd48000, 16'd32000, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd11025, 16'd12000, 16'd8000,  16'd0}
    };

endpackage

`default_nettype wire

FILE: rtl/mahp_decode.sv
// Combinational decode of a complete four-byte MPEG audio header.
// Depends on mahp_pkg for the field struct and the rate tables.
`timescale 1ns / 1ps
`default_nettype none

module mahp_decode (
    input  wire logic [7:0]           byte2,
    input  wire logic [7:0]           byte3,
    input  wire logic [7:0]           byte4,
    output mahp_pkg::hdr_fields_t     fields
);

    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] bidx;
    logic [1:0] sidx;
    logic [2:0] rate_row;
    logic [1:0] freq_row;

    assign ver  = byte2[4:3];
    assign lay  = byte2[2:1];
    assign bidx = byte3[7:4];
    assign sidx = byte3[3:2];

    always_comb
    begin
        if (ver == mahp_pkg::VER_MPEG1)
        begin
            if (lay == mahp_pkg::LAYER_1)
                rate_row = 3'd0;
            else if (lay == mahp_pkg::LAYER_2)
                rate_row = 3'd1;
            else
                rate_row = 3'd2;
        end
        else
        begin
            rate_row = (lay == mahp_pkg::LAYER_1) ? 3'd3 : 3'd4;
        end

        if (ver == mahp_pkg::VER_MPEG1)
            freq_row = 2'd0;
        else if (ver == mahp_pkg::VER_MPEG2)
            freq_row = 2'd1;
        else
            freq_row = 2'd2;
    end

    always_comb
    begin
        fields                   = '0;
        fields.version_code      = ver;
        fields.layer_code        = lay;
        fields.crc_flag          = byte2[0];
        fields.bitrate_kbps      = mahp_pkg::RATE_KBPS[rate_row][bidx];
        fields.bitrate_known     = (bidx != mahp_pkg::BIDX_FREE) && (bidx != mahp_pkg::BIDX_BAD);
        fields.sample_rate_hz    = mahp_pkg::FREQ_HZ[freq_row][sidx];
        fields.sample_rate_known = (sidx != mahp_pkg::SIDX_RSVD);
        fields.padding_flag      = byte3[1];
        fields.chan_mode         = byte4[7:6];
    end

endmodule

`default_nettype wire

FILE: rtl/mpeg_audio_header_parser.sv
// Top level of the MPEG audio frame header parser: input register, sync hunt, result register.
// Depends on mahp_pkg and mahp_decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes one stream byte per cycle (s_tlast marks the last byte of a buffer) and hunts for
// the frame sync 0xFF followed by a byte with its top three bits set. A reserved version or
// layer in the second byte yields an error result on that byte; a completed fourth byte
// yields the decoded header; a buffer end on a byte that gives no other result yields "no sync".
// Sustained rate is one byte per cycle while m_tready stays high; a result held by a low
// m_tready stalls the input. A result shows on m_tvalid after its byte is taken into the input
// register: the input register feeds the sync state machine and table lookup, which load
// the result register.
module mpeg_audio_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_buffer
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] version_code, [3:2] layer_code, [4] crc_flag, [13:5] bitrate_kbps,
    // [14] bitrate_known, [30:15] sample_rate_hz, [31] sample_rate_known,
    // [32] padding_flag, [34:33] chan_mode, [39:35] zero
    output logic [39:0]      m_tdata,
    output logic [1:0]       m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_SYNC  = 4'b0010,
        PH_BYTE3 = 4'b0100,
        PH_BYTE4 = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic [7:0]             held2_reg, held3_reg;
    logic                   held2_we, held3_we;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg;
    mahp_pkg::hdr_fields_t  out_fields_reg;

    logic                   advance;
    logic                   emit;
    logic                   done;
    logic [1:0]             res_status;
    mahp_pkg::hdr_fields_t  res_fields;
    mahp_pkg::hdr_fields_t  dec_fields;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mahp_decode u_decode (
        .byte2  (held2_reg),
        .byte3  (held3_reg),
        .byte4  (in_byte_reg),
        .fields (dec_fields)
    );

    always_comb
    begin
        phase_next = phase_reg;
        emit       = 1'b0;
        done       = 1'b0;
        held2_we   = 1'b0;
        held3_we   = 1'b0;
        res_status = mahp_pkg::ST_OK;
        res_fields = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == mahp_pkg::SYNC_BYTE)
                    phase_next = PH_SYNC;
            end
            PH_SYNC:
            begin
                if ((in_byte_reg & mahp_pkg::SYNC_MASK) == mahp_pkg::SYNC_MASK)
                begin
                    if (in_byte_reg[4:3] == mahp_pkg::VER_RESERVED ||
                        in_byte_reg[2:1] == mahp_pkg::LAYER_RESERVED)
                    begin
                        // error goes out on this byte; version wins over layer
                        emit       = 1'b1;
                        done       = 1'b1;
                        res_status = (in_byte_reg[4:3] == mahp_pkg::VER_RESERVED)
                                     ? mahp_pkg::ST_BAD_VER : mahp_pkg::ST_BAD_LAYER;
                        res_fields.version_code = in_byte_reg[4:3];
                        res_fields.layer_code   = in_byte_reg[2:1];
                        res_fields.crc_flag     = in_byte_reg[0];
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        held2_we   = 1'b1;
                        phase_next = PH_BYTE3;
                    end
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BYTE3:
            begin
                held3_we   = 1'b1;
                phase_next = PH_BYTE4;
            end
            PH_BYTE4:
            begin
                emit       = 1'b1;
                done       = 1'b1;
                res_fields = dec_fields;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        if (!done && in_last_reg)
        begin
            emit       = 1'b1;
            res_status = mahp_pkg::ST_NO_SYNC;
            res_fields = '0;
            phase_next = PH_HUNT;
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && held2_we)
            held2_reg <= in_byte_reg;
        if (advance && held3_we)
            held3_reg <= in_byte_reg;
        if (advance && emit)
        begin
            out_status_reg <= res_status;
            out_fields_reg <= res_fields;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(mahp_pkg::OUT_W - $bits(mahp_pkg::hdr_fields_t)){1'b0}}, out_fields_reg};

    // every emitted result sends the hunt back to the start
    a_emit_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> phase_reg == PH_HUNT)
        else $error("phase not back to hunt after a result");

    // an error result never carries rate information
    a_err_no_rates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != mahp_pkg::ST_OK |->
            m_tdata[14:5] == 10'd0 && m_tdata[31:15] == 17'd0)
        else $error("error result carries rate fields");

    // a good header never has a reserved version or layer
    a_ok_valid_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mahp_pkg::ST_OK |->
            m_tdata[1:0] != mahp_pkg::VER_RESERVED && m_tdata[3:2] != mahp_pkg::LAYER_RESERVED)
        else $error("ok result with reserved version or layer");

endmodule

`default_nettype wire
